// ===== hw/rtl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, codes and field layout for the buddy tree allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  // Default number of tree levels the store is sized for
  localparam int BTA_MAX_LEVELS = 10;

  // Field widths of one request word and one result word
  localparam int REQ_W  = 2;
  localparam int LVL_W  = 4;
  localparam int IDX_W  = 9;
  localparam int KIND_W = 2;
  localparam int VAL_W  = 4;   // width of one stored node value
  localparam int CFG_W  = 4;   // width of the tree depth write word

  // Request tdata layout: node_level, node_index, node_kind, one pad bit
  localparam int IN_LVL_LSB  = 0;
  localparam int IN_IDX_LSB  = IN_LVL_LSB + LVL_W;
  localparam int IN_KIND_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_TDATA_W  = 16;

  // Result tdata layout: kind_read, found, found_level, found_index
  localparam int OUT_TDATA_W = KIND_W + 1 + LVL_W + IDX_W;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SET  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_FIND = 2'd2
  } req_t;

  // Node kinds
  localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONT = 2'd2;

  // Where the next read goes, relative to the cursor node
  typedef enum logic [2:0] {
    AD_CUR,
    AD_SIB,
    AD_UP,
    AD_DOWN,
    AD_RIGHT,
    AD_ROOT
  } addr_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SET_CMP,
    ST_PROP_SIB,
    ST_GET_CLS,
    ST_FIND_CHK,
    ST_FIND_LEFT,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load;         // latch a new request word
    logic      cfg_wr;       // take a new tree depth
    logic      clr_restart;  // restart the clearing sweep
    logic      clr_wr;       // write one entry of the clearing sweep
    logic      rd_en;        // read the store
    addr_sel_t sel;          // read address relative to the cursor
    logic      move;         // cursor follows the read address
    logic      v_max;        // value becomes max(read data, value)
    logic      wr_en;        // write value at the cursor
    logic      res_get;      // capture the node kind
    logic      res_found;    // capture the cursor as the found block
    logic      out_push;     // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    req_t req;        // request code of the word in work
    logic node_ok;    // addressed node lies inside the tree
    logic lvl_ok;     // level lies inside the tree
    logic rd_eq_v;    // read data equals the value register
    logic lvl_zero;   // cursor is at the root
    logic lt_min;     // read data below the wanted order
    logic eq_free;    // read data marks the cursor node wholly free
    logic at_leaf;    // cursor is on the deepest level in use
    logic clr_last;   // clearing sweep on its last entry
    logic out_busy;   // output register full and not taken this cycle
  } stat_t;

endpackage

// ===== hw/rtl/bta_ram.sv =====
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// bta_ctrl
// Request sequencer: steps the datapath through set, get and find walks.
// ----------------------------------------------------------------------------
module bta_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  bta_pkg::stat_t stat,
  output bta_pkg::cmd_t  cmd
);

  import bta_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (!cfg_valid && stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          state_nxt = ST_CLEAR;
        end else if (in_tvalid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.req)
          REQ_SET:  state_nxt = stat.node_ok ? ST_SET_CMP : ST_DONE;
          REQ_GET:  state_nxt = ST_GET_CLS;
          REQ_FIND: state_nxt = stat.lvl_ok ? ST_FIND_CHK : ST_DONE;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_SET_CMP: begin
        if (stat.rd_eq_v || stat.lvl_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PROP_SIB;
        end
      end
      ST_PROP_SIB: state_nxt = ST_SET_CMP;
      ST_GET_CLS:  state_nxt = ST_DONE;
      ST_FIND_CHK: begin
        if (stat.lt_min || stat.eq_free || stat.at_leaf) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FIND_LEFT;
        end
      end
      ST_FIND_LEFT: begin
        // left child too small: try the right one
        if (stat.lt_min) begin
          state_nxt = ST_FIND_CHK;
        end else if (stat.eq_free || stat.at_leaf) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FIND_LEFT;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    cmd.sel   = AD_CUR;
    in_tready = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cfg_ready       = 1'b1;
        cmd.cfg_wr      = cfg_valid;
        cmd.clr_restart = cfg_valid;
        cmd.clr_wr      = 1'b1;
      end
      ST_IDLE: begin
        cfg_ready       = 1'b1;
        in_tready       = !cfg_valid;
        cmd.cfg_wr      = cfg_valid;
        cmd.clr_restart = cfg_valid;
        cmd.load        = in_tvalid && !cfg_valid;
      end
      ST_DISPATCH: begin
        case (stat.req)
          REQ_SET: begin
            cmd.rd_en = stat.node_ok;
          end
          REQ_GET: begin
            cmd.rd_en = 1'b1;
          end
          REQ_FIND: begin
            cmd.rd_en = stat.lvl_ok;
            cmd.sel   = AD_ROOT;
            cmd.move  = stat.lvl_ok;
          end
          default: cmd.rd_en = 1'b0;
        endcase
      end
      ST_SET_CMP: begin
        // write when the value changed, then fetch the sibling if not at root
        cmd.wr_en = !stat.rd_eq_v;
        cmd.rd_en = !stat.rd_eq_v && !stat.lvl_zero;
        cmd.sel   = AD_SIB;
      end
      ST_PROP_SIB: begin
        cmd.v_max = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.sel   = AD_UP;
        cmd.move  = 1'b1;
      end
      ST_GET_CLS: begin
        cmd.res_get = 1'b1;
      end
      ST_FIND_CHK: begin
        cmd.res_found = !stat.lt_min && stat.eq_free;
        cmd.rd_en     = !stat.lt_min && !stat.eq_free && !stat.at_leaf;
        cmd.sel       = AD_DOWN;
        cmd.move      = cmd.rd_en;
      end
      ST_FIND_LEFT: begin
        if (stat.lt_min) begin
          cmd.rd_en = 1'b1;
          cmd.sel   = AD_RIGHT;
          cmd.move  = 1'b1;
        end else begin
          cmd.res_found = stat.eq_free;
          cmd.rd_en     = !stat.eq_free && !stat.at_leaf;
          cmd.sel       = AD_DOWN;
          cmd.move      = cmd.rd_en;
        end
      end
      ST_DONE: begin
        cmd.out_push = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bta_dp.sv =====
// ----------------------------------------------------------------------------
// bta_dp
// Datapath: node store, cursor, value and result registers, output register.
// ----------------------------------------------------------------------------
module bta_dp #(
  parameter int MAX_LEVELS = bta_pkg::BTA_MAX_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bta_pkg::cmd_t                   cmd,
  output bta_pkg::stat_t                  stat,
  input  logic [bta_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [bta_pkg::REQ_W-1:0]       in_tuser,
  input  logic [bta_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bta_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import bta_pkg::*;

  localparam int AW    = MAX_LEVELS;
  localparam int DEPTH = 1 << MAX_LEVELS;
  localparam int DW    = $clog2(MAX_LEVELS + 1);

  // Request fields
  logic [LVL_W-1:0]  in_level;
  logic [IDX_W-1:0]  in_idx;
  logic [KIND_W-1:0] in_kind;

  assign in_level = in_tdata[IN_LVL_LSB +: LVL_W];
  assign in_idx   = in_tdata[IN_IDX_LSB +: IDX_W];
  assign in_kind  = in_tdata[IN_KIND_LSB +: KIND_W];

  // Registers
  logic [DW-1:0]     depth_r;
  logic [DW-1:0]     depth_nxt;
  logic [AW-1:0]     clr_cnt_r;
  req_t              req_r;
  logic              ok_r;
  logic              lvl_ok_r;
  logic [DW-1:0]     level_r;
  logic [AW-1:0]     idx_r;
  logic [VAL_W-1:0]  v_r;
  logic [DW-1:0]     minv_r;
  logic [KIND_W-1:0] kind_r;
  logic              found_r;
  logic [LVL_W-1:0]  flvl_r;
  logic [IDX_W-1:0]  fidx_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Store ports
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [VAL_W-1:0] ram_wr_data;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  // Cursor candidate and slots
  logic [DW-1:0] lv_sel;
  logic [AW-1:0] ix_sel;
  logic [AW:0]   rd_slot;
  logic [AW:0]   cur_slot;
  logic          node_ok_in;
  logic          lvl_ok_in;

  // Depth register with clamping to 1..MAX_LEVELS
  always_comb begin
    if (cfg_data == '0) begin
      depth_nxt = DW'(1);
    end else if (32'(cfg_data) > MAX_LEVELS) begin
      depth_nxt = DW'(MAX_LEVELS);
    end else begin
      depth_nxt = DW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DW'(MAX_LEVELS);
    end else if (cmd.cfg_wr) begin
      depth_r <= depth_nxt;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_restart) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Range checks on the incoming word
  assign lvl_ok_in  = 32'(in_level) < 32'(depth_r);
  assign node_ok_in = lvl_ok_in && ((in_idx >> in_level) == '0);

  // Read address: the cursor or one of its neighbors
  always_comb begin
    lv_sel = level_r;
    ix_sel = idx_r;
    case (cmd.sel)
      AD_CUR:   ix_sel = idx_r;
      AD_SIB:   ix_sel = idx_r ^ AW'(1);
      AD_UP: begin
        lv_sel = level_r - DW'(1);
        ix_sel = idx_r >> 1;
      end
      AD_DOWN: begin
        lv_sel = level_r + DW'(1);
        ix_sel = idx_r << 1;
      end
      AD_RIGHT: ix_sel = idx_r | AW'(1);
      AD_ROOT: begin
        lv_sel = '0;
        ix_sel = '0;
      end
      default: ix_sel = idx_r;
    endcase
  end

  // Heap-order slot: 2^level - 1 + index
  assign rd_slot  = ((AW+1)'(1) << lv_sel) - (AW+1)'(1) + (AW+1)'(ix_sel);
  assign cur_slot = ((AW+1)'(1) << level_r) - (AW+1)'(1) + (AW+1)'(idx_r);
  assign rd_addr  = rd_slot[AW-1:0];

  // Write port: clearing sweep or the cursor node
  always_comb begin
    if (cmd.clr_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt_r;
      ram_wr_data = (clr_cnt_r == '0) ? VAL_W'(depth_r) : '0;
    end else begin
      ram_wr_en   = cmd.wr_en;
      ram_wr_addr = cur_slot[AW-1:0];
      ram_wr_data = v_r;
    end
  end

  bta_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request context, cursor and value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_t'(in_tuser);
      ok_r     <= node_ok_in;
      lvl_ok_r <= lvl_ok_in;
      level_r  <= DW'(in_level);
      idx_r    <= AW'(in_idx);
      minv_r   <= DW'(32'(depth_r) - 32'(in_level));
      if (in_kind == KIND_FREE) begin
        v_r <= VAL_W'(32'(depth_r) - 32'(in_level));
      end else begin
        v_r <= '0;
      end
    end else begin
      if (cmd.move) begin
        level_r <= lv_sel;
        idx_r   <= ix_sel;
      end
      if (cmd.v_max && (rd_data > v_r)) begin
        v_r <= rd_data;
      end
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= KIND_FREE;
      found_r <= 1'b0;
      flvl_r  <= '0;
      fidx_r  <= '0;
    end else begin
      if (cmd.res_get) begin
        if (!ok_r || rd_data == '0) begin
          kind_r <= KIND_DATA;
        end else if (stat.eq_free) begin
          kind_r <= KIND_FREE;
        end else begin
          kind_r <= KIND_CONT;
        end
      end
      if (cmd.res_found) begin
        found_r <= 1'b1;
        flvl_r  <= LVL_W'(level_r);
        fidx_r  <= IDX_W'(idx_r);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      out_data_r <= {fidx_r, flvl_r, found_r, kind_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status
  always_comb begin
    stat.req      = req_r;
    stat.node_ok  = ok_r;
    stat.lvl_ok   = lvl_ok_r;
    stat.rd_eq_v  = rd_data == v_r;
    stat.lvl_zero = level_r == '0;
    stat.lt_min   = 32'(rd_data) < 32'(minv_r);
    stat.eq_free  = 32'(rd_data) == (32'(depth_r) - 32'(level_r));
    stat.at_leaf  = (32'(level_r) + 32'd1) >= 32'(depth_r);
    stat.clr_last = clr_cnt_r == '1;
    stat.out_busy = out_valid_r && !out_tready;
  end

endmodule

// ===== hw/rtl/buddy_tree_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_tree_allocator
// Buddy allocator kept as a max-order tree, with set, get and find requests.
//
// Each node of a complete binary tree stores the largest free order below it
// (depth - level for a wholly free node, 0 for a used one), in a one-port-
// write, one-port-read RAM of 2^MAX_LEVELS entries. Requests are handled one
// at a time and the RAM read latency paces every step. A get reads the node
// and classifies it. A set writes the node when its value changes, then does
// a sibling read and a parent read for each level the max propagates upward.
// A find walks down from the root, left child first, reading the right child
// when the left one is too small. A finished result sits in an output
// register, and the next request is taken while it waits. After reset and
// after every write of tree_depth the store is rebuilt by a clearing pass
// over all 2^MAX_LEVELS entries (1024 by default) during which no request
// is accepted; depth writes are still taken during the pass and restart it.
// ----------------------------------------------------------------------------
module buddy_tree_allocator #(
  parameter int MAX_LEVELS = bta_pkg::BTA_MAX_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] node_level, [12:4] node_index, [14:13] node_kind, [15] zero
  input  logic [bta_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [bta_pkg::REQ_W-1:0]       in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] kind_read, [2] found, [6:3] found_level, [15:7] found_index
  output logic [bta_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tree depth write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bta_pkg::CFG_W-1:0]       cfg_data
);

  import bta_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store and registers
  bta_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // One request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in work");

  // A depth write starts a clearing pass that holds off requests
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_tready)
    else $error("request taken right after a depth write");

  // The store is never written in the cycle a request is taken
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!cmd.wr_en && !cmd.clr_wr))
    else $error("store written while accepting a request");

endmodule

// ===== tb/buddy_tree_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_tree_allocator_tb
// Self-checking bench for the max-order buddy tree allocator.
//
// Set, get and find requests go in as stream words and are mirrored into a
// local copy of the node store, which yields the expected reply for each
// accepted word. Replies are checked in order, field by field. The run covers
// hand-picked corner requests, depth writes at both ends of the range,
// allocate/free traffic with random content, and a long output stall that
// backs the request channel up.
// ----------------------------------------------------------------------------
module buddy_tree_allocator_tb;
  import bta_pkg::*;

  // Codes with no name in the package
  localparam logic [REQ_W-1:0]  REQ_NONE  = 2'd3;   // unused request code
  localparam logic [KIND_W-1:0] KIND_ALT  = 2'd3;   // stored like a container
  localparam int                STORE_N   = 1 << BTA_MAX_LEVELS;

  // One reply word, laid out as on out_tdata
  typedef struct packed {
    logic [IDX_W-1:0]  found_index;
    logic [LVL_W-1:0]  found_level;
    logic              found;
    logic [KIND_W-1:0] kind_read;
  } tree_reply_t;

  typedef struct {
    int unsigned lvl;
    int unsigned idx;
  } tree_node_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  // Local copy of the node store and depth register
  logic [VAL_W-1:0] tree_orders [0:STORE_N-1];
  int unsigned      depth_cur;

  tree_reply_t      pending_replies [$];
  tree_node_t       held_blocks [$];
  int               err_count = 0;
  bit               idle_on = 1'b0;
  int               long_hold_req = 0;

  buddy_tree_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Store mirror
  // --------------------------------------------------------------------------
  function automatic int unsigned slot(int unsigned lvl, int unsigned idx);
    return ((1 << lvl) - 1 + idx) & (STORE_N - 1);
  endfunction

  function automatic bit node_inside(int unsigned lvl, int unsigned idx);
    return (lvl < depth_cur) && (idx < (1 << lvl));
  endfunction

  // Depth write: clamp, then wipe the store with only the root free
  function automatic void take_depth(logic [CFG_W-1:0] d);
    depth_cur = (d == 0) ? 1 : ((d > BTA_MAX_LEVELS) ? BTA_MAX_LEVELS : d);
    foreach (tree_orders[k]) tree_orders[k] = '0;
    tree_orders[0] = depth_cur[VAL_W-1:0];
  endfunction

  // Apply one request to the mirror and return the reply it must produce
  function automatic tree_reply_t predict_tree_response(logic [REQ_W-1:0] rq,
      logic [LVL_W-1:0] level, logic [IDX_W-1:0] index, logic [KIND_W-1:0] kind);
    tree_reply_t res;
    int unsigned lvl, idx, nv, np, sib, v, minv, nmax, cl, ci;
    bit          walking;
    res = '0;
    lvl = level;
    idx = index;
    case (rq)
      REQ_SET: begin
        if (node_inside(lvl, idx)) begin
          nv = (kind == KIND_FREE) ? depth_cur - lvl : 0;
          if (nv != tree_orders[slot(lvl, idx)]) begin
            tree_orders[slot(lvl, idx)] = nv[VAL_W-1:0];
            // climb with the max of each sibling pair, stop at first match
            walking = 1'b1;
            while (walking && lvl > 0) begin
              sib = tree_orders[slot(lvl, idx ^ 1)];
              np  = (sib > nv) ? sib : nv;
              lvl = lvl - 1;
              idx = idx >> 1;
              if (tree_orders[slot(lvl, idx)] == np) begin
                walking = 1'b0;
              end else begin
                tree_orders[slot(lvl, idx)] = np[VAL_W-1:0];
                nv = np;
              end
            end
          end
        end
      end
      REQ_GET: begin
        if (!node_inside(lvl, idx)) begin
          res.kind_read = KIND_DATA;
        end else begin
          v = tree_orders[slot(lvl, idx)];
          if (v == 0) res.kind_read = KIND_DATA;
          else if (v == depth_cur - lvl) res.kind_read = KIND_FREE;
          else res.kind_read = KIND_CONT;
        end
      end
      REQ_FIND: begin
        if (lvl < depth_cur) begin
          minv    = depth_cur - lvl;
          nmax    = depth_cur;
          cl      = 0;
          ci      = 0;
          v       = tree_orders[0];
          walking = 1'b1;
          // descend, left child first, bounded by the depth in use
          while (walking) begin
            if (v < minv) begin
              walking = 1'b0;
            end else if (v == nmax) begin
              res.found       = 1'b1;
              res.found_level = cl[LVL_W-1:0];
              res.found_index = ci[IDX_W-1:0];
              walking         = 1'b0;
            end else if (cl + 1 >= depth_cur) begin
              walking = 1'b0;
            end else begin
              nmax = nmax - 1;
              cl   = cl + 1;
              ci   = ci << 1;
              v    = tree_orders[slot(cl, ci)];
              if (v < minv) begin
                ci = ci | 1;
                v  = tree_orders[slot(cl, ci)];
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one word, wait for the handshake, record the reply it must give
  task automatic send_req(input logic [REQ_W-1:0] rq, input int unsigned lvl,
      input int unsigned idx, input logic [KIND_W-1:0] kind, output tree_reply_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq;
    in_tdata  <= {1'b0, kind, idx[IDX_W-1:0], lvl[LVL_W-1:0]};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    res = predict_tree_response(rq, lvl[LVL_W-1:0], idx[IDX_W-1:0], kind);
    pending_replies.push_back(res);
  endtask

  // Stop offering and wait until every reply is back
  task automatic wait_replies_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic write_depth(input logic [CFG_W-1:0] d);
    wait_replies_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    take_depth(d);
    held_blocks.delete();
  endtask

  // Mixed traffic: allocate via find, free held blocks, random legal words
  // and some fully random noise
  task automatic run_traffic(input int n_items);
    tree_reply_t res;
    tree_node_t  nd;
    int          sel, k;
    int unsigned lvl, idx;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      lvl = $urandom_range(0, depth_cur - 1);
      idx = $urandom_range(0, (1 << lvl) - 1);
      if (sel < 30) begin
        send_req(REQ_FIND, lvl, $urandom_range(0, 511), KIND_W'($urandom_range(0, 3)),
                 res);
        if (res.found) begin
          nd.lvl = res.found_level;
          nd.idx = res.found_index;
          send_req(REQ_SET, nd.lvl, nd.idx,
                   ($urandom_range(0, 3) == 0) ? KIND_CONT : KIND_DATA, res);
          held_blocks.push_back(nd);
        end
      end else if (sel < 50 && held_blocks.size() > 0) begin
        k  = $urandom_range(0, held_blocks.size() - 1);
        nd = held_blocks[k];
        held_blocks.delete(k);
        send_req(REQ_SET, nd.lvl, nd.idx, KIND_FREE, res);
        if ($urandom_range(0, 1)) send_req(REQ_GET, nd.lvl, nd.idx, KIND_FREE, res);
      end else if (sel < 70) begin
        send_req(REQ_SET, lvl, idx, KIND_W'($urandom_range(0, 3)), res);
      end else if (sel < 85) begin
        send_req(REQ_GET, lvl, idx, KIND_W'($urandom_range(0, 3)), res);
      end else begin
        send_req(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                 $urandom_range(0, 511), KIND_W'($urandom_range(0, 3)), res);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply side
  // --------------------------------------------------------------------------
  // Random stalls in bursts, or one long hold when asked for
  initial begin : reply_ready_gen
    int n;
    forever begin
      if (long_hold_req > 0) begin
        n = long_hold_req;
        long_hold_req = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
      input logic [IDX_W-1:0] got);
    if (got !== want[IDX_W-1:0]) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    tree_reply_t got;
    tree_reply_t want;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected, expected nothing, got %h",
                 $time, out_tdata);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("kind_read", want.kind_read, got.kind_read);
        check_field("found", want.found, got.found);
        check_field("found_level", want.found_level, got.found_level);
        check_field("found_index", want.found_index, got.found_index);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Depth 10 straight out of reset: corner requests
  task automatic test_reset_corners();
    tree_reply_t r;
    send_req(REQ_GET,  0, 0, KIND_FREE, r);    // root free after reset
    send_req(REQ_FIND, 0, 0, KIND_FREE, r);    // whole tree
    send_req(REQ_FIND, 9, 0, KIND_FREE, r);    // smallest block, root found
    send_req(REQ_FIND, 10, 0, KIND_FREE, r);   // wanted level too deep
    send_req(REQ_FIND, 15, 511, KIND_ALT, r);
    send_req(REQ_SET,  1, 0, KIND_FREE, r);    // root drops to 9
    send_req(REQ_FIND, 0, 0, KIND_FREE, r);
    send_req(REQ_FIND, 5, 0, KIND_FREE, r);
    send_req(REQ_SET,  9, 511, KIND_FREE, r);  // long climb on the right edge
    send_req(REQ_GET,  8, 255, KIND_FREE, r);
    send_req(REQ_SET,  1, 0, KIND_CONT, r);    // container over a free subtree
    send_req(REQ_FIND, 9, 0, KIND_FREE, r);    // walks right down to the leaf
    send_req(REQ_GET,  0, 0, KIND_FREE, r);
    send_req(REQ_GET,  9, 511, KIND_FREE, r);
    send_req(REQ_SET,  9, 511, KIND_ALT, r);   // kind three acts as container
    send_req(REQ_FIND, 9, 0, KIND_FREE, r);
    send_req(REQ_SET,  10, 0, KIND_FREE, r);   // level out of range
    send_req(REQ_SET,  2, 4, KIND_FREE, r);    // index out of range
    send_req(REQ_GET,  12, 0, KIND_FREE, r);
    send_req(REQ_GET,  3, 8, KIND_FREE, r);
    send_req(REQ_NONE, 15, 511, KIND_ALT, r);  // unknown request
    send_req(REQ_SET,  0, 0, KIND_FREE, r);
    send_req(REQ_GET,  0, 0, KIND_DATA, r);
  endtask

  // Depth written as 0 (clamped to 1), then 1 itself
  task automatic test_depth_one();
    tree_reply_t r;
    write_depth(4'd0);
    send_req(REQ_GET,  0, 0, KIND_FREE, r);
    send_req(REQ_FIND, 0, 0, KIND_FREE, r);
    send_req(REQ_FIND, 1, 0, KIND_FREE, r);
    send_req(REQ_SET,  0, 0, KIND_DATA, r);
    send_req(REQ_FIND, 0, 0, KIND_FREE, r);
    send_req(REQ_SET,  1, 0, KIND_FREE, r);
    send_req(REQ_SET,  0, 0, KIND_FREE, r);
    write_depth(4'd1);
    idle_on = 1'b1;
    run_traffic(60);
  endtask

  // Depth written above the maximum (clamped to 10), random traffic
  task automatic test_depth_clamped_high();
    write_depth(4'd15);
    run_traffic(400);
  endtask

  task automatic test_small_depths();
    write_depth(4'd3);
    run_traffic(250);
    write_depth(4'd6);
    run_traffic(250);
  endtask

  // Long output stall while words keep coming, then a pause until drained
  task automatic test_backpressure_fill();
    tree_reply_t r;
    int unsigned lvl;
    write_depth(4'd4);
    idle_on = 1'b0;
    long_hold_req = 300;
    for (int n = 0; n < 40; n++) begin
      lvl = $urandom_range(0, 3);
      send_req(REQ_W'($urandom_range(0, 2)), lvl, $urandom_range(0, (1 << lvl) - 1),
               KIND_W'($urandom_range(0, 3)), r);
    end
    wait_replies_drained();
    idle_on = 1'b1;
    run_traffic(100);
  endtask

  // Full depth again, no idling on either side
  task automatic test_full_rate();
    write_depth(4'd10);
    idle_on = 1'b0;
    run_traffic(350);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_SET;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    take_depth(4'(BTA_MAX_LEVELS));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_corners();
    test_depth_one();
    test_depth_clamped_high();
    test_small_depths();
    test_backpressure_fill();
    test_full_rate();

    wait_replies_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending_replies.size() == 0) begin
      $display("buddy_tree_allocator: match");
    end else begin
      $display("buddy_tree_allocator: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("buddy_tree_allocator: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bta_pkg.sv
hw/rtl/bta_ram.sv
hw/rtl/bta_ctrl.sv
hw/rtl/bta_dp.sv
hw/rtl/buddy_tree_allocator.sv
tb/buddy_tree_allocator_tb.sv
